// File: design/sfm_pkg.sv
`timescale 1ns / 1ps

package sfm_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int COUNT_BITS   = 16;
  localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
  localparam int TOT_BITS     = $clog2(TABLE_DEPTH + 1);
  localparam int SYM_BITS     = 8;
  localparam int OUT_CNT_BITS = 16;
  localparam int REM_BITS     = 9;
  localparam int ENTRY_BITS   = SYM_BITS + COUNT_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic CMD_COUNT  = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef logic [SYM_BITS-1:0]   sym_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [TOT_BITS-1:0]   tot_t;

  typedef struct packed {
    logic dv;
    logic first;
    logic max_mode;
  } scan_ctl_t;

endpackage

// File: design/sfm_ram.sv
`timescale 1ns / 1ps

module sfm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/sfm_scan.sv
`timescale 1ns / 1ps

module sfm_scan
  import sfm_pkg::*;
(
  input  logic      clk,
  input  scan_ctl_t ctl,
  input  sym_t      key_sym,
  input  sym_t      rd_sym,
  input  cnt_t      rd_cnt,
  input  idx_t      rd_idx,
  output logic      match,
  output cnt_t      cnt_inc,
  output idx_t      best_idx,
  output sym_t      best_sym,
  output cnt_t      best_cnt
);

  idx_t best_idx_r;
  sym_t best_sym_r;
  cnt_t best_cnt_r;
  logic take_best;

  // Strictly greater keeps the earliest entry on a tie.
  assign take_best = ctl.dv && ctl.max_mode && (ctl.first || (rd_cnt > best_cnt_r));
  assign match     = ctl.dv && !ctl.max_mode && (rd_sym == key_sym);
  assign cnt_inc   = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + cnt_t'(1);

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_idx_r <= rd_idx;
      best_sym_r <= rd_sym;
      best_cnt_r <= rd_cnt;
    end
  end

  assign best_idx = best_idx_r;
  assign best_sym = best_sym_r;
  assign best_cnt = best_cnt_r;

endmodule

// File: design/symbol_frequency_max_extract_top.sv
`timescale 1ns / 1ps
// Byte symbol histogram with extraction of the most frequent entry.
// Input channel in_*: in_tuser is the command (0 counts the symbol in in_tdata,
// 1 removes the entry with the largest count, the earliest one on a tie).
// Output channel out_*: one item for each removal command and none for a count.
// The table sits in a single-port-write, single-port-read RAM, and every
// command walks the stored entries one per cycle through one compare unit.
// A count keeps in_tready low while it searches the stored entries, then raises
// the symbol's count (saturating) or appends it as a new entry unless the table
// is full, so the block takes no new item before it is done with the last.
// A removal searches all stored entries (ST_MAX), settles the winner
// (ST_MAX_END), moves the entries behind it up one place (ST_SHIFT) and loads
// the result into the output register (ST_DONE), which raises out_tvalid.
// A removal on an empty table goes straight to ST_DONE. in_tready is high
// only while the sequencer is idle.
// A removal result waits in the output register until out_tready is high;
// meanwhile the block already takes the next item, and a second removal
// holds in its final step until the register frees.
// A synchronous reset on rst_n empties the table at once.
module symbol_frequency_max_extract_top
  import sfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // symbol[7:0]
  input  logic        in_tuser,   // command[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_symbol[7:0], out_count[23:8], remaining[32:24], zeros
  output logic        out_tuser   // found[0]
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT,
    ST_MAX,
    ST_MAX_END,
    ST_SHIFT,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  sym_t   sym_r, sym_nxt;
  tot_t   tot_r, tot_nxt;
  tot_t   idx_r, idx_nxt;
  logic   dv_r, dv_nxt;
  idx_t   didx_r, didx_nxt;
  logic   fnd_r, fnd_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_found_r, out_found_nxt;
  logic [39:0] out_data_r, out_data_nxt;

  logic rd_en, wr_en;
  idx_t wr_addr;
  logic [ENTRY_BITS-1:0] wr_data, rd_data;
  sym_t rd_sym, best_sym;
  cnt_t rd_cnt, cnt_inc, best_cnt;
  idx_t best_idx;
  logic match, last, issue_ok, accept;
  tot_t tot_m1;
  scan_ctl_t ctl;

  assign rd_sym   = rd_data[SYM_BITS-1:0];
  assign rd_cnt   = rd_data[ENTRY_BITS-1:SYM_BITS];
  assign tot_m1   = tot_r - tot_t'(1);
  assign last     = dv_r && ({1'b0, didx_r} == tot_m1);
  assign issue_ok = (idx_r < tot_r);
  assign accept   = in_tvalid && in_tready;

  assign ctl.dv       = dv_r;
  assign ctl.first    = (didx_r == '0);
  assign ctl.max_mode = (state_r == ST_MAX);

  sfm_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r[IDX_BITS-1:0]),
    .rd_data (rd_data)
  );

  sfm_scan u_scan (
    .clk      (clk),
    .ctl      (ctl),
    .key_sym  (sym_r),
    .rd_sym   (rd_sym),
    .rd_cnt   (rd_cnt),
    .rd_idx   (didx_r),
    .match    (match),
    .cnt_inc  (cnt_inc),
    .best_idx (best_idx),
    .best_sym (best_sym),
    .best_cnt (best_cnt)
  );

  always_comb begin
    state_nxt     = state_r;
    sym_nxt       = sym_r;
    tot_nxt       = tot_r;
    idx_nxt       = idx_r;
    didx_nxt      = idx_r[IDX_BITS-1:0];
    fnd_nxt       = fnd_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = didx_r;
    wr_data       = rd_data;
    in_tready     = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sym_nxt = in_tdata;
          idx_nxt = '0;
          if (in_tuser == CMD_COUNT) begin
            state_nxt = ST_CNT;
          end else if (tot_r == '0) begin
            fnd_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            fnd_nxt   = 1'b1;
            state_nxt = ST_MAX;
          end
        end
      end
      ST_CNT: begin
        if (match) begin
          wr_en     = 1'b1;
          wr_addr   = didx_r;
          wr_data   = {cnt_inc, rd_sym};
          state_nxt = ST_IDLE;
        end else if ((tot_r == '0) || last) begin
          if (tot_r != tot_t'(TABLE_DEPTH)) begin
            wr_en   = 1'b1;
            wr_addr = tot_r[IDX_BITS-1:0];
            wr_data = {cnt_t'(1), sym_r};
            tot_nxt = tot_r + tot_t'(1);
          end
          state_nxt = ST_IDLE;
        end else if (issue_ok) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + tot_t'(1);
        end
      end
      ST_MAX: begin
        if (last) begin
          state_nxt = ST_MAX_END;
        end else if (issue_ok) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + tot_t'(1);
        end
      end
      ST_MAX_END: begin
        idx_nxt   = {1'b0, best_idx} + tot_t'(1);
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (dv_r) begin
          wr_en   = 1'b1;
          wr_addr = didx_r - idx_t'(1);
          wr_data = rd_data;
        end
        if (issue_ok) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + tot_t'(1);
        end else if (!dv_r) begin
          tot_nxt   = tot_m1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = fnd_r;
          if (fnd_r) begin
            out_data_nxt = {7'd0, REM_BITS'(tot_r), OUT_CNT_BITS'(best_cnt), best_sym};
          end else begin
            out_data_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    dv_nxt = rd_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tot_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tot_r       <= tot_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sym_r       <= sym_nxt;
    idx_r       <= idx_nxt;
    didx_r      <= didx_nxt;
    fnd_r       <= fnd_nxt;
    out_found_r <= out_found_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

endmodule
